@@ sv/first_fit_region_allocator_defines.svh @@
// Assertion macros for the first-fit region allocator checker.
// Included by ffra_checker.sv; no other dependencies.
`ifndef FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FFRA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffra assertion failed");

// next-cycle implication, disabled in reset
`define FFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffra assertion failed");

`endif

@@ sv/ffra_pkg.sv @@
// Shared types, codes and constants of the first-fit region allocator.
// No dependencies; imported by every RTL module of the block.
package ffra_pkg;

    localparam int ENTRIES_DEF = 64;
    // alignment granule, power of two
    localparam int ALIGN_BYTES = 16;
    localparam logic [32:0] ALIGN_ADD  = 33'(ALIGN_BYTES - 1);
    localparam logic [32:0] ALIGN_MASK = ~ALIGN_ADD;
    localparam logic [31:0] LIMIT_RESET = 32'h3fff_ffff;

    typedef enum logic [1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_RESERVE = 2'd1,
        FUNC_ALLOC   = 2'd2,
        FUNC_FREE    = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_NOFIT    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTALLOC = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [31:0] amount;
    } req_t;

    typedef struct packed {
        logic [31:0] result_address;
        logic [2:0]  status;
    } rsp_t;

    typedef enum logic [2:0] {
        SCAN_EMPTY    = 3'd0,
        SCAN_FIT      = 3'd1,
        SCAN_BOUND    = 3'd2,
        SCAN_ALLOC_AT = 3'd3,
        SCAN_FREE_AT  = 3'd4,
        SCAN_FREE_END = 3'd5
    } scan_mode_t;

    typedef enum logic [3:0] {
        ACT_NONE          = 4'd0,
        ACT_ADD_WR        = 4'd1,
        ACT_AL_TAKE       = 4'd2,
        ACT_AL_NEW        = 4'd3,
        ACT_AL_SHRINK     = 4'd4,
        ACT_FR_LATCH      = 4'd5,
        ACT_FR_MERGE_NEXT = 4'd6,
        ACT_FR_MERGE_PREV = 4'd7,
        ACT_FR_RELEASE    = 4'd8,
        ACT_RES_INIT      = 4'd9,
        ACT_RES_SPLIT     = 4'd10,
        ACT_RES_CUT       = 4'd11,
        ACT_RES_TRIM      = 4'd12
    } act_t;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        scan_mode_t scan_mode;
        act_t       act;
        logic       out_load;
        status_t    code;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  scan_done;
        logic  found;
        logic  empty_found;
        logic  add_ignore;
        logic  alloc_zero;
        logic  res_rev;
        logic  fit_exact;
        logic  res_split;
    } dp_stat_t;

    function automatic logic [32:0] align_up(input logic [32:0] x);
        return (x + ALIGN_ADD) & ALIGN_MASK;
    endfunction

endpackage

@@ sv/ffra_ctrl.sv @@
// Sequencing state machine of the region allocator.
// Depends on ffra_pkg; drives ffra_datapath through dp_cmd_t / dp_stat_t.
module ffra_ctrl
    import ffra_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_ready,
    output logic     out_valid,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_DECODE    = 14'b00000000000010,
        S_ADD_SCAN  = 14'b00000000000100,
        S_RES_START = 14'b00000000001000,
        S_RES_SCAN  = 14'b00000000010000,
        S_RES_CUT   = 14'b00000000100000,
        S_AL_SCAN   = 14'b00000001000000,
        S_AL_SHRINK = 14'b00000010000000,
        S_FR_SCAN1  = 14'b00000100000000,
        S_FR_START2 = 14'b00001000000000,
        S_FR_SCAN2  = 14'b00010000000000,
        S_FR_START3 = 14'b00100000000000,
        S_FR_SCAN3  = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                code_next = ST_DONE;
                case (stat.func)
                    FUNC_ADD:
                    begin
                        if (stat.add_ignore)
                        begin
                            code_next  = ST_IGNORED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_EMPTY;
                            state_next     = S_ADD_SCAN;
                        end
                    end
                    FUNC_RESERVE:
                    begin
                        if (stat.res_rev)
                        begin
                            code_next  = ST_IGNORED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.act    = ACT_RES_INIT;
                            state_next = S_RES_START;
                        end
                    end
                    FUNC_ALLOC:
                    begin
                        if (stat.alloc_zero)
                        begin
                            code_next  = ST_IGNORED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_mode  = SCAN_FIT;
                            state_next     = S_AL_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_mode  = SCAN_ALLOC_AT;
                        state_next     = S_FR_SCAN1;
                    end
                endcase
            end
            S_ADD_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.empty_found)
                    begin
                        cmd.act = ACT_ADD_WR;
                    end
                    else
                    begin
                        code_next = ST_FULL;
                    end
                    state_next = S_DONE;
                end
            end
            S_RES_START:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_mode  = SCAN_BOUND;
                state_next     = S_RES_SCAN;
            end
            S_RES_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (!stat.found)
                    begin
                        state_next = S_DONE;
                    end
                    else if (stat.res_split)
                    begin
                        // full table: the upper part of the region is dropped
                        if (stat.empty_found)
                        begin
                            cmd.act = ACT_RES_SPLIT;
                        end
                        else
                        begin
                            code_next = ST_FULL;
                        end
                        state_next = S_RES_CUT;
                    end
                    else
                    begin
                        cmd.act    = ACT_RES_TRIM;
                        state_next = S_RES_START;
                    end
                end
            end
            S_RES_CUT:
            begin
                cmd.act    = ACT_RES_CUT;
                state_next = S_DONE;
            end
            S_AL_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (!stat.found)
                    begin
                        code_next  = ST_NOFIT;
                        state_next = S_DONE;
                    end
                    else if (stat.fit_exact)
                    begin
                        cmd.act    = ACT_AL_TAKE;
                        state_next = S_DONE;
                    end
                    else if (!stat.empty_found)
                    begin
                        code_next  = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.act    = ACT_AL_NEW;
                        state_next = S_AL_SHRINK;
                    end
                end
            end
            S_AL_SHRINK:
            begin
                cmd.act    = ACT_AL_SHRINK;
                state_next = S_DONE;
            end
            S_FR_SCAN1:
            begin
                if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        cmd.act    = ACT_FR_LATCH;
                        state_next = S_FR_START2;
                    end
                    else
                    begin
                        code_next  = ST_NOTALLOC;
                        state_next = S_DONE;
                    end
                end
            end
            S_FR_START2:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_mode  = SCAN_FREE_AT;
                state_next     = S_FR_SCAN2;
            end
            S_FR_SCAN2:
            begin
                if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        cmd.act = ACT_FR_MERGE_NEXT;
                    end
                    state_next = S_FR_START3;
                end
            end
            S_FR_START3:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_mode  = SCAN_FREE_END;
                state_next     = S_FR_SCAN3;
            end
            S_FR_SCAN3:
            begin
                if (stat.scan_done)
                begin
                    cmd.act    = stat.found ? ACT_FR_MERGE_PREV : ACT_FR_RELEASE;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.code = code_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ sv/ffra_datapath.sv @@
// Region table, scan engine and arithmetic of the region allocator.
// Depends on ffra_pkg; commanded by ffra_ctrl.
module ffra_datapath
    import ffra_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        in_data,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    output rsp_t        out_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
    localparam logic [32:0]   BOUND_INIT = 33'h1_0000_0000;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] stamp;
    } entry_t;

    entry_t mem [ENTRIES];

    logic [ENTRIES-1:0] used_reg, used_next;
    logic [ENTRIES-1:0] alloc_reg, alloc_next;
    logic [31:0]        limit_reg;
    logic [31:0]        stamp_reg, stamp_next;

    req_t        req_reg;
    logic [32:0] key_reg;
    logic [31:0] head_reg;
    logic [IW-1:0] cur_reg;
    logic [31:0] len_cur_reg;
    logic [31:0] res_addr_reg;
    rsp_t        out_reg;

    // scan engine
    logic          busy_reg, done_reg, found_reg, empty_found_reg;
    logic [CW-1:0] cnt_reg;
    logic          rd_valid_reg;
    logic [IW-1:0] rd_idx_reg, best_idx_reg, empty_idx_reg;
    entry_t        rd_entry_reg, best_reg;
    scan_mode_t    mode_reg;

    logic        issue, hit, take, rd_used, rd_alloc, rd_free;
    logic [32:0] rd_end;

    // request arithmetic
    logic [32:0] base33, amt33, lim33, add_head, add_end_raw, add_end, size33, rt33;
    logic [32:0] best_start33, best_end, eh2, et2;
    logic        add_ignore, res_split, res_gone;

    logic          wr_en;
    logic [IW-1:0] wr_idx;
    entry_t        wr_entry;

    assign base33      = {1'b0, req_reg.address};
    assign amt33       = {1'b0, req_reg.amount};
    assign lim33       = {1'b0, limit_reg};
    assign add_head    = align_up(base33);
    assign add_end_raw = base33 + amt33;
    assign add_end     = (add_end_raw > lim33) ? lim33 : add_end_raw;
    assign add_ignore  = (req_reg.amount == 32'd0) || (base33 > lim33) || (add_head >= add_end);
    assign size33      = align_up(amt33);
    assign rt33        = amt33 + 33'd1;

    assign best_start33 = {1'b0, best_reg.start};
    assign best_end     = best_start33 + {1'b0, best_reg.len};
    assign res_split    = (best_start33 < base33) && (rt33 < best_end);
    assign eh2 = ((base33 <= best_start33) && (best_start33 <= rt33)) ? rt33 : best_start33;
    assign et2 = ((base33 <= best_end) && (best_end <= rt33)) ? base33 : best_end;
    assign res_gone = (eh2 >= et2);

    always_comb
    begin
        stat.func        = func_t'(req_reg.func);
        stat.scan_done   = done_reg;
        stat.found       = found_reg;
        stat.empty_found = empty_found_reg;
        stat.add_ignore  = add_ignore;
        stat.alloc_zero  = (req_reg.amount == 32'd0);
        stat.res_rev     = (req_reg.amount < req_reg.address);
        stat.fit_exact   = ({1'b0, best_reg.len} == size33);
        stat.res_split   = res_split;
    end

    // candidate test on the entry read last cycle
    assign issue    = busy_reg && (cnt_reg < CNT_END);
    assign rd_used  = used_reg[rd_idx_reg];
    assign rd_alloc = alloc_reg[rd_idx_reg];
    assign rd_free  = rd_used && !rd_alloc;
    assign rd_end   = {1'b0, rd_entry_reg.start} + {1'b0, rd_entry_reg.len};

    always_comb
    begin
        case (mode_reg)
            SCAN_FIT:      hit = rd_free && ({1'b0, rd_entry_reg.len} >= size33);
            SCAN_BOUND:    hit = rd_free && ({1'b0, rd_entry_reg.stamp} < key_reg);
            SCAN_ALLOC_AT: hit = rd_used && rd_alloc && (rd_entry_reg.start == req_reg.address);
            SCAN_FREE_AT:  hit = rd_free && ({1'b0, rd_entry_reg.start} == key_reg);
            SCAN_FREE_END: hit = rd_free && (rd_idx_reg != cur_reg)
                                 && (rd_end == {1'b0, head_reg});
            default:       hit = 1'b0;
        endcase
    end

    // newest wins; ties keep the lower slot
    assign take = rd_valid_reg && hit && (!found_reg || (rd_entry_reg.stamp > best_reg.stamp));

    always_comb
    begin
        wr_en      = 1'b0;
        wr_idx     = best_idx_reg;
        wr_entry   = best_reg;
        used_next  = used_reg;
        alloc_next = alloc_reg;
        stamp_next = stamp_reg;
        case (cmd.act)
            ACT_ADD_WR:
            begin
                wr_en    = 1'b1;
                wr_idx   = empty_idx_reg;
                wr_entry = '{start: add_head[31:0], len: 32'(add_end - add_head),
                             stamp: stamp_reg};
                used_next[empty_idx_reg]  = 1'b1;
                alloc_next[empty_idx_reg] = 1'b0;
                stamp_next = stamp_reg + 32'd1;
            end
            ACT_AL_TAKE:
            begin
                wr_en          = 1'b1;
                wr_entry.stamp = stamp_reg;
                alloc_next[best_idx_reg] = 1'b1;
                stamp_next = stamp_reg + 32'd1;
            end
            ACT_AL_NEW:
            begin
                wr_en    = 1'b1;
                wr_idx   = empty_idx_reg;
                wr_entry = '{start: best_reg.start, len: size33[31:0], stamp: stamp_reg};
                used_next[empty_idx_reg]  = 1'b1;
                alloc_next[empty_idx_reg] = 1'b1;
                stamp_next = stamp_reg + 32'd1;
            end
            ACT_AL_SHRINK:
            begin
                wr_en          = 1'b1;
                wr_entry.start = best_reg.start + size33[31:0];
                wr_entry.len   = best_reg.len - size33[31:0];
            end
            ACT_FR_MERGE_NEXT:
            begin
                wr_en          = 1'b1;
                wr_entry.start = head_reg;
                wr_entry.len   = best_reg.len + len_cur_reg;
                used_next[cur_reg]  = 1'b0;
                alloc_next[cur_reg] = 1'b0;
            end
            ACT_FR_MERGE_PREV:
            begin
                wr_en        = 1'b1;
                wr_entry.len = best_reg.len + len_cur_reg;
                used_next[cur_reg]  = 1'b0;
                alloc_next[cur_reg] = 1'b0;
            end
            ACT_FR_RELEASE:
            begin
                wr_en    = 1'b1;
                wr_idx   = cur_reg;
                wr_entry = '{start: head_reg, len: len_cur_reg, stamp: stamp_reg};
                alloc_next[cur_reg] = 1'b0;
                stamp_next = stamp_reg + 32'd1;
            end
            ACT_RES_SPLIT:
            begin
                wr_en    = 1'b1;
                wr_idx   = empty_idx_reg;
                wr_entry = '{start: rt33[31:0], len: 32'(best_end - rt33), stamp: stamp_reg};
                used_next[empty_idx_reg]  = 1'b1;
                alloc_next[empty_idx_reg] = 1'b0;
                stamp_next = stamp_reg + 32'd1;
            end
            ACT_RES_CUT:
            begin
                wr_en        = 1'b1;
                wr_entry.len = 32'(base33 - best_start33);
            end
            ACT_RES_TRIM:
            begin
                if (res_gone)
                begin
                    used_next[best_idx_reg]  = 1'b0;
                    alloc_next[best_idx_reg] = 1'b0;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wr_entry.start = eh2[31:0];
                    wr_entry.len   = 32'(et2 - eh2);
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (issue)
        begin
            rd_entry_reg <= mem[cnt_reg[IW-1:0]];
            rd_idx_reg   <= cnt_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg        <= '0;
            alloc_reg       <= '0;
            stamp_reg       <= 32'd0;
            limit_reg       <= LIMIT_RESET;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            cnt_reg         <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            alloc_reg    <= alloc_next;
            stamp_reg    <= stamp_next;
            rd_valid_reg <= issue;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.scan_start)
            begin
                busy_reg        <= 1'b1;
                done_reg        <= 1'b0;
                found_reg       <= 1'b0;
                empty_found_reg <= 1'b0;
                cnt_reg         <= '0;
            end
            else
            begin
                if (issue)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                if (rd_valid_reg && (rd_idx_reg == LAST_IDX))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
                if (rd_valid_reg && !rd_used)
                begin
                    empty_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            mode_reg <= cmd.scan_mode;
        end
        if (take)
        begin
            best_reg     <= rd_entry_reg;
            best_idx_reg <= rd_idx_reg;
        end
        if (rd_valid_reg && !rd_used && !empty_found_reg)
        begin
            empty_idx_reg <= rd_idx_reg;
        end
        if (cmd.load)
        begin
            req_reg      <= in_data;
            res_addr_reg <= 32'd0;
        end
        case (cmd.act)
            ACT_AL_TAKE, ACT_AL_NEW:
            begin
                res_addr_reg <= best_reg.start;
            end
            ACT_FR_LATCH:
            begin
                cur_reg     <= best_idx_reg;
                head_reg    <= best_reg.start;
                len_cur_reg <= best_reg.len;
                key_reg     <= best_end;
            end
            ACT_FR_MERGE_NEXT:
            begin
                cur_reg     <= best_idx_reg;
                len_cur_reg <= best_reg.len + len_cur_reg;
            end
            ACT_RES_INIT:
            begin
                key_reg <= BOUND_INIT;
            end
            ACT_RES_TRIM:
            begin
                key_reg <= {1'b0, best_reg.stamp};
            end
            default:
            begin
                key_reg <= key_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_reg <= '{result_address: res_addr_reg, status: cmd.code};
        end
    end

    assign out_data = out_reg;

endmodule

@@ sv/first_fit_region_allocator.sv @@
// First-fit region allocator with coalescing: top level.
// Uses ffra_pkg, ffra_ctrl and ffra_datapath.
//
// Requests come in on in_valid/in_ready/in_data (func, address, amount);
// one response per request leaves on out_valid/out_ready/out_data
// (result_address, status). cfg_valid/cfg_ready/cfg_data write memory_limit;
// cfg_ready is always high, and writes belong in idle periods.
// Every request that is not ignored walks the region table entry by entry
// through one read port of the table memory: add and allocate walk it once,
// a free of an allocated block three times, and reserve once more than the
// free regions it trims. An allocate that splits a region writes the new
// entry and then shrinks the old one; a reserve that splits a region writes
// the upper part, unless the table is full, and then cuts the lower part.
// Ignored requests skip the walk. One request is in work at a time.
// The response sits in an output register; a new request is taken while it
// waits, but that request's response stalls until out_ready takes the old one.
// Reset empties the table at once (per-entry valid bits), clears the stamp
// counter and sets memory_limit to 0x3fffffff; no clearing pass is needed.
module first_fit_region_allocator
    import ffra_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output rsp_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    ffra_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    ffra_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

@@ sv/ffra_checker.sv @@
// Port-level checker for the region allocator, bound to the top level.
// Depends on ffra_pkg and first_fit_region_allocator_defines.svh.
`include "first_fit_region_allocator_defines.svh"

module ffra_assert_checker
    import ffra_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input req_t        in_data,
    input logic        out_valid,
    input logic        out_ready,
    input rsp_t        out_data,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [31:0] cfg_data
);

    // one request in work at a time
    `FFRA_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready)

    // a response only appears after the engine has been busy
    `FFRA_ASSERT_IMPL(a_resp_after_work, clk, rst_n, $rose(out_valid), $past(!in_ready))

    // only a successful allocate carries an address
    `FFRA_ASSERT_IMPL(a_addr_only_done, clk, rst_n,
        out_valid && (out_data.status != ST_DONE), out_data.result_address == 32'd0)

    // a stalled response holds
    `FFRA_ASSERT_NEXT(a_resp_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data))

endmodule

bind first_fit_region_allocator ffra_assert_checker u_ffra_assert_checker (.*);

@@ dv/ffra_checker.sv @@
`timescale 1ns / 100ps
// Checker for the first-fit region allocator: keeps its own copy of the region table,
// predicts one response per accepted request and compares it with what the block returns.
// Depends on ffra_pkg for the request, response and code types.
module ffra_checker
    import ffra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  req_t        in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  rsp_t        out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          outstanding
);

    localparam int SLOTS = 64;

    bit [31:0] seg_base  [SLOTS];
    bit [31:0] seg_len   [SLOTS];
    bit        seg_taken [SLOTS];
    bit [31:0] seg_stamp [SLOTS];
    bit [31:0] stamp_ctr;
    bit [31:0] top_addr;

    rsp_t expected_rsp[$];

    function automatic bit [63:0] round16(bit [63:0] x);
        return (x + 64'd15) / 64'd16 * 64'd16;
    endfunction

    function automatic bit is_free(int i);
        return seg_len[i] != 0 && !seg_taken[i];
    endfunction

    function automatic bit is_taken(int i);
        return seg_len[i] != 0 && seg_taken[i];
    endfunction

    function automatic bit newer(int c, int b);
        return b < 0 || seg_stamp[c] > seg_stamp[b];
    endfunction

    function automatic int vacant();
        for (int i = 0; i < SLOTS; i++)
            if (seg_len[i] == 0)
                return i;
        return -1;
    endfunction

    function automatic void wipe(int i);
        seg_base[i] = 0;
        seg_len[i] = 0;
        seg_taken[i] = 0;
        seg_stamp[i] = 0;
    endfunction

    function automatic void claim(int k, bit [31:0] b, bit [31:0] l, bit t);
        seg_base[k] = b;
        seg_len[k] = l;
        seg_taken[k] = t;
        seg_stamp[k] = stamp_ctr;
        stamp_ctr = stamp_ctr + 1;
    endfunction

    function automatic status_t do_add(bit [63:0] b, bit [63:0] l);
        bit [63:0] head;
        bit [63:0] tail;
        int k;
        if (l == 0 || b > top_addr)
            return ST_IGNORED;
        head = round16(b);
        tail = b + l;
        if (tail > top_addr)
            tail = top_addr;
        if (head >= tail)
            return ST_IGNORED;
        k = vacant();
        if (k < 0)
            return ST_FULL;
        claim(k, head[31:0], 32'(tail - head), 1'b0);
        return ST_DONE;
    endfunction

    function automatic status_t do_reserve(bit [63:0] lo, bit [63:0] last);
        bit [63:0] hi;
        bit [63:0] bound;
        bit [63:0] eh;
        bit [63:0] et;
        int e;
        int k;
        status_t st;
        hi = last + 1;
        bound = 64'h1_0000_0000;
        st = ST_DONE;
        if (last < lo)
            return ST_IGNORED;
        forever
        begin
            e = -1;
            for (int i = 0; i < SLOTS; i++)
                if (is_free(i) && seg_stamp[i] < bound && newer(i, e))
                    e = i;
            if (e < 0)
                break;
            bound = seg_stamp[e];
            eh = seg_base[e];
            et = eh + seg_len[e];
            // range strictly inside: split, upper part needs a slot
            if (eh < lo && hi < et)
            begin
                k = vacant();
                if (k >= 0)
                    claim(k, hi[31:0], 32'(et - hi), 1'b0);
                else
                    st = ST_FULL;
                seg_len[e] = 32'(lo - eh);
                break;
            end
            if (lo <= eh && eh <= hi)
                eh = hi;
            if (lo <= et && et <= hi)
                et = lo;
            if (eh >= et)
                wipe(e);
            else
            begin
                seg_base[e] = eh[31:0];
                seg_len[e] = 32'(et - eh);
            end
        end
        return st;
    endfunction

    function automatic status_t do_alloc(bit [63:0] amt, output bit [31:0] where);
        bit [63:0] size;
        int e;
        int k;
        where = 0;
        e = -1;
        if (amt == 0)
            return ST_IGNORED;
        size = round16(amt);
        for (int i = 0; i < SLOTS; i++)
            if (is_free(i) && seg_len[i] >= size && newer(i, e))
                e = i;
        if (e < 0)
            return ST_NOFIT;
        if (seg_len[e] == size)
        begin
            seg_taken[e] = 1;
            seg_stamp[e] = stamp_ctr;
            stamp_ctr = stamp_ctr + 1;
            where = seg_base[e];
            return ST_DONE;
        end
        k = vacant();
        if (k < 0)
            return ST_FULL;
        claim(k, seg_base[e], size[31:0], 1'b1);
        where = seg_base[k];
        seg_base[e] = seg_base[e] + size[31:0];
        seg_len[e] = seg_len[e] - size[31:0];
        return ST_DONE;
    endfunction

    function automatic status_t do_free(bit [31:0] a);
        bit [63:0] head;
        bit [63:0] tail;
        int e;
        int n;
        int p;
        int cur;
        e = -1;
        n = -1;
        p = -1;
        for (int i = 0; i < SLOTS; i++)
            if (is_taken(i) && seg_base[i] == a && newer(i, e))
                e = i;
        if (e < 0)
            return ST_NOTALLOC;
        head = seg_base[e];
        tail = head + seg_len[e];
        for (int i = 0; i < SLOTS; i++)
            if (is_free(i) && 64'(seg_base[i]) == tail && newer(i, n))
                n = i;
        cur = e;
        if (n >= 0)
        begin
            seg_base[n] = head[31:0];
            seg_len[n] = seg_len[n] + seg_len[e];
            wipe(e);
            cur = n;
        end
        head = seg_base[cur];
        for (int i = 0; i < SLOTS; i++)
            if (i != cur && is_free(i) && 64'(seg_base[i]) + seg_len[i] == head
                && newer(i, p))
                p = i;
        if (p >= 0)
        begin
            seg_len[p] = seg_len[p] + seg_len[cur];
            wipe(cur);
        end
        else
        begin
            seg_taken[cur] = 0;
            seg_stamp[cur] = stamp_ctr;
            stamp_ctr = stamp_ctr + 1;
        end
        return ST_DONE;
    endfunction

    function automatic rsp_t predict_response(req_t r);
        rsp_t rsp;
        bit [31:0] where;
        where = 0;
        case (func_t'(r.func))
            FUNC_ADD:     rsp.status = do_add(r.address, r.amount);
            FUNC_RESERVE: rsp.status = do_reserve(r.address, r.amount);
            FUNC_ALLOC:   rsp.status = do_alloc(r.amount, where);
            default:      rsp.status = do_free(r.address);
        endcase
        rsp.result_address = where;
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                wipe(i);
            stamp_ctr = 0;
            top_addr = LIMIT_RESET;
            expected_rsp.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                top_addr = cfg_data;
            if (in_valid && in_ready)
                expected_rsp.push_back(predict_response(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ffra: response with no request pending: addr %h status %0d",
                                 out_data.result_address, out_data.status);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (want.result_address !== out_data.result_address
                        || want.status !== out_data.status)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ffra: mismatch: exp addr %h status %0d, got addr %h status %0d",
                                     want.result_address, want.status,
                                     out_data.result_address, out_data.status);
                    end
                end
            end
        end
        outstanding = expected_rsp.size();
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for first_fit_region_allocator: drives requests, responses stalls and
// memory_limit writes; ffra_checker (dv/ffra_checker.sv) predicts and compares.
module tb_top
    import ffra_pkg::*;
();

    localparam int QUIET_LIMIT = 40000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    req_t        in_data;
    logic        out_valid;
    logic        out_ready;
    rsp_t        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int errors;
    int outstanding;
    int tx_idle;
    int rx_idle;
    int quiet;
    bit [31:0] live_blocks[$];

    first_fit_region_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ffra_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle);
        // remember allocated blocks so that frees mostly hit
        if (rst_n && out_valid && out_ready && out_data.status == ST_DONE
            && out_data.result_address != 0 && live_blocks.size() < 128)
            live_blocks.push_back(out_data.result_address);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic send(func_t f, bit [31:0] a, bit [31:0] n);
        while ($urandom_range(99) < tx_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{func: f, address: a, amount: n};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_limit(bit [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int pick;
        int idx;
        bit [31:0] a;
        pick = $urandom_range(99);
        if (pick < 8)
            send(func_t'($urandom_range(3)), $urandom, $urandom);
        else if (pick < 23)
            send(FUNC_ADD, $urandom_range(32'h3ffff), $urandom_range(32'h3000, 1));
        else if (pick < 35)
        begin
            a = $urandom_range(32'h3ffff);
            send(FUNC_RESERVE, a, a + $urandom_range(32'h800));
        end
        else if (pick < 70)
            send(FUNC_ALLOC, 32'h0, $urandom_range(32'h400, 1));
        else if (live_blocks.size() != 0 && $urandom_range(9) != 0)
        begin
            idx = $urandom_range(live_blocks.size() - 1);
            a = live_blocks[idx];
            live_blocks.delete(idx);
            send(FUNC_FREE, a, $urandom);
        end
        else
            send(FUNC_FREE, $urandom_range(32'h3ffff) & 32'hffff_fff0, $urandom);
    endtask

    initial
    begin
        bit [31:0] limits[4];
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        tx_idle = 29;
        rx_idle = 77;
        quiet = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset limit
        send(FUNC_ALLOC, 32'h0, 32'h0);
        send(FUNC_ALLOC, 32'h0, 32'h10);
        send(FUNC_FREE, 32'h100, 32'h0);
        send(FUNC_ADD, 32'h1000, 32'h0);
        send(FUNC_ADD, 32'h4000_0000, 32'h100);
        send(FUNC_ADD, 32'hffff_ffff, 32'hffff_ffff);
        send(FUNC_ADD, 32'h3fff_fff5, 32'h100);
        send(FUNC_ADD, 32'h1003, 32'h1000);
        send(FUNC_ADD, 32'h8000, 32'h2000);
        send(FUNC_RESERVE, 32'h9000, 32'h8000);
        send(FUNC_RESERVE, 32'h8100, 32'h81ff);
        send(FUNC_ALLOC, 32'h0, 32'hffff_ffff);
        send(FUNC_ALLOC, 32'h0, 32'h10);
        send(FUNC_ALLOC, 32'h0, 32'h11);
        send(FUNC_FREE, 32'h8200, 32'h0);
        send(FUNC_FREE, 32'h8210, 32'h0);
        send(FUNC_FREE, 32'h8210, 32'h0);
        send(FUNC_ALLOC, 32'h0, 32'h1e00);
        send(FUNC_ADD, 32'h0, 32'hffff_ffff);
        send(FUNC_RESERVE, 32'h0, 32'hffff_ffff);
        send(FUNC_RESERVE, 32'hffff_ffff, 32'hffff_ffff);
        drain();

        limits[0] = 32'hffff_ffff;
        limits[1] = 32'h0000_c000;
        limits[2] = 32'h0;
        limits[3] = $urandom_range(32'h3ffff, 32'h800);
        for (int p = 0; p < 4; p++)
        begin
            write_limit(limits[p]);
            if (p == 1)
            begin
                tx_idle = 77;
                rx_idle = 29;
            end
            else if (p >= 2)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            for (int n = 0; n < 420; n++)
                random_request();
            drain();
        end

        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
